// ----- hdl/sfec_pkg.sv -----
// Shared constants and types for the symmetric FIR with clamped record edges.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package sfec_pkg;

   localparam int MAX_HALF_WIDTH_DEF = 5;
   localparam int SAMPLE_BITS_DEF    = 16;

   localparam int COEF_BITS     = 24;
   localparam int OUT_BITS      = 24;
   localparam int FRAC_BITS     = 16;
   localparam int NUM_COEF      = 6;
   localparam int HW_REG_BITS   = 3;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 24;

   localparam logic                   BACK_ADD_RST   = 1'b1;
   localparam logic [HW_REG_BITS-1:0] HALF_WIDTH_RST = 3'd2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_BACK_ADD    = 3'd0,
      REG_HALF_WIDTH  = 3'd1,
      REG_COEF_CENTRE = 3'd2,
      REG_COEF_ONE    = 3'd3,
      REG_COEF_TWO    = 3'd4,
      REG_COEF_THREE  = 3'd5,
      REG_COEF_FOUR   = 3'd6,
      REG_COEF_FIVE   = 3'd7
   } csr_reg_type;

   // load enables of the datapath stages behind the window
   typedef struct packed {
      logic pre;
      logic mul;
      logic pair;
      logic total;
      logic out;
   } stg_en_type;

   // window cell control
   typedef struct packed {
      logic load;
      logic fill;
   } win_ctl_type;

endpackage

`default_nettype wire

// ----- hdl/symmetric_fir_edge_clamp.sv -----
// Top level of the symmetric FIR with clamped record edges: window cells, lanes, sum.
// Depends on sfec_pkg, sfec_cell, sfec_lane and sfec_sum.
//
//   channel | ports                                   | direction
//   req     | req_valid req_ready req_sample req_final_req | in, valid/ready
//   rsp     | rsp_valid rsp_ready rsp_filtered rsp_end_of_record | out, valid/ready
//   csr     | csr_we csr_index csr_wdata              | in, write only
//
// One sample per cycle is taken while no record end is being flushed and the
// stages are not all full. After the sample marked final, input is held off while
// the window cells shift in copies of the last sample to produce the owed items.
// A result passes the pre-add, multiply, pair, total and output registers after the
// window step that completes it; stages behind the window close bubbles, so input
// stalls only when every stage is full. Reset clears control state and loads register defaults.
`default_nettype none

module symmetric_fir_edge_clamp #(
   parameter int MAX_HALF_WIDTH = sfec_pkg::MAX_HALF_WIDTH_DEF,
   parameter int SAMPLE_BITS    = sfec_pkg::SAMPLE_BITS_DEF
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  wire logic                                req_final_req,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [sfec_pkg::OUT_BITS-1:0]     rsp_filtered,
   output logic                                     rsp_end_of_record,
   input  wire logic                                csr_we,
   input  wire logic [sfec_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [sfec_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int WIN_DEPTH    = 2 * MAX_HALF_WIDTH + 1;
   localparam int WIN_IDX_BITS = $clog2(WIN_DEPTH);
   localparam int HW_BITS      = $clog2(MAX_HALF_WIDTH + 1);
   localparam int NUM_LANES    = (MAX_HALF_WIDTH < sfec_pkg::NUM_COEF - 1) ?
                                 MAX_HALF_WIDTH + 1 : sfec_pkg::NUM_COEF;
   localparam int NUM_STG      = 6;
   localparam int M_W          = SAMPLE_BITS + 1 + sfec_pkg::COEF_BITS;
   localparam logic [HW_BITS-1:0] FILL_MAX = HW_BITS'(MAX_HALF_WIDTH);

   // configuration registers
   logic                                    back_add_ff;
   logic [sfec_pkg::HW_REG_BITS-1:0]        half_width_ff;
   logic signed [sfec_pkg::COEF_BITS-1:0]   coef_ff [sfec_pkg::NUM_COEF];

   // record control
   logic               in_record_ff, in_record_in;
   logic [HW_BITS-1:0] fill_ff, fill_in;
   logic [HW_BITS-1:0] flush_ff, flush_in;
   logic [NUM_STG-1:0] vld_ff, vld_in;
   logic [NUM_STG-1:0] eor_ff;
   logic [NUM_STG-1:0] free;

   logic               h_over;
   logic [HW_BITS-1:0] h_eff;
   logic [WIN_IDX_BITS-1:0] h_idx;
   logic               flushing;
   logic               accept;
   logic               step;
   logic               emit;
   logic               emit_eor;
   logic [HW_BITS-1:0] fill_inc;

   sfec_pkg::win_ctl_type win_ctl;
   sfec_pkg::stg_en_type  stg_en;

   logic signed [SAMPLE_BITS-1:0] win [WIN_DEPTH];
   logic signed [SAMPLE_BITS-1:0] lane_fwd [NUM_LANES];
   logic signed [SAMPLE_BITS-1:0] lane_bwd [NUM_LANES];
   logic                          lane_sub [NUM_LANES];
   logic signed [M_W-1:0]         lane_prod [NUM_LANES];

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         back_add_ff   <= sfec_pkg::BACK_ADD_RST;
         half_width_ff <= sfec_pkg::HALF_WIDTH_RST;
         for (int i = 0; i < sfec_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            sfec_pkg::REG_BACK_ADD:    back_add_ff   <= csr_wdata[0];
            sfec_pkg::REG_HALF_WIDTH:  half_width_ff <= csr_wdata[sfec_pkg::HW_REG_BITS-1:0];
            sfec_pkg::REG_COEF_CENTRE: coef_ff[0]    <= csr_wdata[sfec_pkg::COEF_BITS-1:0];
            sfec_pkg::REG_COEF_ONE:    coef_ff[1]    <= csr_wdata[sfec_pkg::COEF_BITS-1:0];
            sfec_pkg::REG_COEF_TWO:    coef_ff[2]    <= csr_wdata[sfec_pkg::COEF_BITS-1:0];
            sfec_pkg::REG_COEF_THREE:  coef_ff[3]    <= csr_wdata[sfec_pkg::COEF_BITS-1:0];
            sfec_pkg::REG_COEF_FOUR:   coef_ff[4]    <= csr_wdata[sfec_pkg::COEF_BITS-1:0];
            sfec_pkg::REG_COEF_FIVE:   coef_ff[5]    <= csr_wdata[sfec_pkg::COEF_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      h_over = int'(half_width_ff) > MAX_HALF_WIDTH;
      h_eff  = h_over ? HW_BITS'(MAX_HALF_WIDTH) : HW_BITS'(half_width_ff);
      h_idx  = WIN_IDX_BITS'(h_eff);

      // a stage can take new data when empty or when its item moves on
      free[NUM_STG-1] = !vld_ff[NUM_STG-1] || rsp_ready;
      for (int i = NUM_STG - 2; i >= 0; i--) begin
         free[i] = !vld_ff[i] || free[i+1];
      end

      flushing  = flush_ff != '0;
      req_ready = free[0] && !flushing;
      accept    = req_valid && req_ready;
      step      = free[0] && (accept || flushing);
      fill_inc  = (fill_ff == FILL_MAX) ? fill_ff : fill_ff + HW_BITS'(1);

      in_record_in = in_record_ff;
      fill_in      = fill_ff;
      flush_in     = flush_ff;
      emit_eor     = 1'b0;
      if (accept) begin
         fill_in      = in_record_ff ? fill_inc : '0;
         in_record_in = !req_final_req;
         flush_in     = req_final_req ? h_eff : '0;
         emit_eor     = req_final_req && (h_eff == '0);
      end else if (step) begin
         // flush: shift in a copy of the last sample
         fill_in  = fill_inc;
         flush_in = flush_ff - HW_BITS'(1);
         emit_eor = flush_ff == HW_BITS'(1);
      end
      emit = step && (fill_in >= h_eff);

      vld_in[0] = free[0] ? emit : vld_ff[0];
      for (int i = 1; i < NUM_STG; i++) begin
         vld_in[i] = free[i] ? vld_ff[i-1] : vld_ff[i];
      end

      win_ctl.load = step;
      win_ctl.fill = accept && !in_record_ff;

      stg_en.pre   = free[1];
      stg_en.mul   = free[2];
      stg_en.pair  = free[3];
      stg_en.total = free[4];
      stg_en.out   = free[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_record_ff <= 1'b0;
         fill_ff      <= '0;
         flush_ff     <= '0;
         vld_ff       <= '0;
      end else begin
         in_record_ff <= in_record_in;
         fill_ff      <= fill_in;
         flush_ff     <= flush_in;
         vld_ff       <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free[0]) begin
         eor_ff[0] <= emit_eor;
      end
      for (int i = 1; i < NUM_STG; i++) begin
         if (free[i]) begin
            eor_ff[i] <= eor_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------- window
   for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] shift_d;
      if (i == 0) begin : g_head
         assign shift_d = flushing ? win[0] : req_sample;
      end else begin : g_body
         assign shift_d = win[i-1];
      end
      sfec_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock   (clock),
         .ctl     (win_ctl),
         .fill_d  (req_sample),
         .shift_d (shift_d),
         .data    (win[i])
      );
   end

   // ---------------------------------------------------------------- lanes
   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      if (k == 0) begin : g_centre
         assign lane_fwd[k] = win[h_idx];
         assign lane_bwd[k] = '0;
         assign lane_sub[k] = 1'b0;
      end else begin : g_side
         logic                    lane_use;
         logic [WIN_IDX_BITS-1:0] fidx;
         logic [WIN_IDX_BITS-1:0] bidx;
         // offsets beyond the half width contribute nothing
         assign lane_use    = WIN_IDX_BITS'(k) <= h_idx;
         assign fidx        = lane_use ? h_idx - WIN_IDX_BITS'(k) : '0;
         assign bidx        = lane_use ? h_idx + WIN_IDX_BITS'(k) : '0;
         assign lane_fwd[k] = lane_use ? win[fidx] : '0;
         assign lane_bwd[k] = lane_use ? win[bidx] : '0;
         assign lane_sub[k] = !back_add_ff;
      end
      sfec_lane #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
         .clock (clock),
         .en    (stg_en),
         .fwd   (lane_fwd[k]),
         .bwd   (lane_bwd[k]),
         .sub   (lane_sub[k]),
         .coef  (coef_ff[k]),
         .prod  (lane_prod[k])
      );
   end

   sfec_sum #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .NUM_LANES   (NUM_LANES)
   ) u_sum (
      .clock    (clock),
      .en       (stg_en),
      .prod     (lane_prod),
      .filtered (rsp_filtered)
   );

   assign rsp_valid         = vld_ff[NUM_STG-1];
   assign rsp_end_of_record = eor_ff[NUM_STG-1];

   // ---------------------------------------------------------------- checks
   a_flush_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_final_req && h_eff != '0) |=> flush_ff != '0)
      else $error("final item with nonzero half width did not start a flush");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("fill count beyond maximum half width");

   a_flush_closed: assert property (@(posedge clock) disable iff (reset)
      flushing |-> !in_record_ff)
      else $error("flush running while record open");

   a_eor_closed: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && eor_ff[0]) |-> (!in_record_ff && !flushing))
      else $error("end of record item while record still open or flushing");

endmodule

`default_nettype wire

// ----- hdl/sfec_cell.sv -----
// One tap of the sample window: holds a sample and hands it to its neighbor.
// Depends on sfec_pkg for the control struct.
`default_nettype none

module sfec_cell #(
   parameter int SAMPLE_BITS = sfec_pkg::SAMPLE_BITS_DEF
) (
   input  wire                            clock,
   input  wire sfec_pkg::win_ctl_type     ctl,
   input  wire logic signed [SAMPLE_BITS-1:0] fill_d,
   input  wire logic signed [SAMPLE_BITS-1:0] shift_d,
   output logic signed [SAMPLE_BITS-1:0]  data
);

   logic signed [SAMPLE_BITS-1:0] data_ff;
   logic signed [SAMPLE_BITS-1:0] data_in;

   // record start loads every cell with the first sample
   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = ctl.fill ? fill_d : shift_d;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ----- hdl/sfec_lane.sv -----
// One coefficient lane: pre-add or pre-subtract of the tap pair, then multiply by the coefficient.
// Depends on sfec_pkg for widths and the stage enable struct.
`default_nettype none

module sfec_lane #(
   parameter int SAMPLE_BITS = sfec_pkg::SAMPLE_BITS_DEF
) (
   input  wire                                          clock,
   input  wire sfec_pkg::stg_en_type                    en,
   input  wire logic signed [SAMPLE_BITS-1:0]           fwd,
   input  wire logic signed [SAMPLE_BITS-1:0]           bwd,
   input  wire logic                                    sub,
   input  wire logic signed [sfec_pkg::COEF_BITS-1:0]   coef,
   output logic signed [SAMPLE_BITS+sfec_pkg::COEF_BITS:0] prod
);

   localparam int P_W = SAMPLE_BITS + 1;
   localparam int M_W = P_W + sfec_pkg::COEF_BITS;

   logic signed [P_W-1:0] pre_ff;
   logic signed [P_W-1:0] pre_in;
   logic signed [M_W-1:0] prod_ff;
   logic signed [M_W-1:0] prod_in;

   always_comb begin
      if (sub) begin
         pre_in = P_W'(fwd) - P_W'(bwd);
      end else begin
         pre_in = P_W'(fwd) + P_W'(bwd);
      end
      prod_in = M_W'(pre_ff) * M_W'(coef);
   end

   always_ff @(posedge clock) begin
      if (en.pre) begin
         pre_ff <= pre_in;
      end
      if (en.mul) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ----- hdl/sfec_sum.sv -----
// Adder tree over the lane products, round half up, shift and saturate.
// Depends on sfec_pkg for widths, fraction bits and the stage enable struct.
`default_nettype none

module sfec_sum #(
   parameter int SAMPLE_BITS = sfec_pkg::SAMPLE_BITS_DEF,
   parameter int NUM_LANES   = sfec_pkg::NUM_COEF
) (
   input  wire                                  clock,
   input  wire sfec_pkg::stg_en_type            en,
   input  wire logic signed [SAMPLE_BITS+sfec_pkg::COEF_BITS:0] prod [NUM_LANES],
   output logic signed [sfec_pkg::OUT_BITS-1:0] filtered
);

   localparam int M_W      = SAMPLE_BITS + 1 + sfec_pkg::COEF_BITS;
   localparam int KEEP_W   = sfec_pkg::OUT_BITS + sfec_pkg::FRAC_BITS;
   localparam int TW       = (M_W + 3 > KEEP_W + 1) ? M_W + 3 : KEEP_W + 1;
   localparam int NUM_PAIR = sfec_pkg::NUM_COEF / 2;
   localparam logic signed [TW-1:0] ROUND = TW'(1) <<< (sfec_pkg::FRAC_BITS - 1);

   logic signed [TW-1:0] term [sfec_pkg::NUM_COEF];
   logic signed [TW-1:0] pair_ff [NUM_PAIR];
   logic signed [TW-1:0] total_ff;
   logic signed [TW-1:0] total_in;
   logic signed [sfec_pkg::OUT_BITS-1:0] filtered_ff;
   logic signed [sfec_pkg::OUT_BITS-1:0] filtered_in;
   logic [TW-KEEP_W:0] hi_bits;

   // missing lanes contribute nothing
   for (genvar j = 0; j < sfec_pkg::NUM_COEF; j++) begin : g_term
      if (j < NUM_LANES) begin : g_used
         assign term[j] = TW'(prod[j]);
      end else begin : g_pad
         assign term[j] = '0;
      end
   end

   always_comb begin
      total_in = pair_ff[0] + pair_ff[1] + pair_ff[2] + ROUND;
      hi_bits  = total_ff[TW-1:KEEP_W-1];
      // clamp when the bits above the result are not pure sign
      if ((&hi_bits) || !(|hi_bits)) begin
         filtered_in = total_ff[KEEP_W-1:sfec_pkg::FRAC_BITS];
      end else if (total_ff[TW-1]) begin
         filtered_in = {1'b1, {(sfec_pkg::OUT_BITS-1){1'b0}}};
      end else begin
         filtered_in = {1'b0, {(sfec_pkg::OUT_BITS-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en.pair) begin
         for (int j = 0; j < NUM_PAIR; j++) begin
            pair_ff[j] <= term[2*j] + term[2*j+1];
         end
      end
      if (en.total) begin
         total_ff <= total_in;
      end
      if (en.out) begin
         filtered_ff <= filtered_in;
      end
   end

   assign filtered = filtered_ff;

endmodule

`default_nettype wire
